/* rtl/rfca_pkg.sv */
// ----------------------------------------------------------------------------
// rfca_pkg
// Types and constants shared by the radar frame count averager.
// ----------------------------------------------------------------------------
package rfca_pkg;

    localparam logic [7:0] HEAD0 = 8'h53;
    localparam logic [7:0] HEAD1 = 8'h59;
    localparam logic [7:0] TAIL0 = 8'h54;
    localparam logic [7:0] TAIL1 = 8'h43;

    localparam int unsigned POINT_SIZE       = 11;
    localparam int unsigned POINT_SIZE_SHIFT = 19;
    localparam logic [31:0] POINT_SIZE_RECIP =
        32'(((64'd1 << POINT_SIZE_SHIFT) + POINT_SIZE - 1) / POINT_SIZE);

    localparam logic [16:0] ELAPSED_MAX = 17'h10000;

    localparam logic [7:0]  CFG_TIMEOUT_MS     = 8'd0;
    localparam logic [7:0]  CFG_REPORT_COMMAND = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET      = 16'd5000;
    localparam logic [15:0] REPORT_RESET       = 16'h8202;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = 3;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STORED    = 3'd1,
        EV_BAD_SUM   = 3'd2,
        EV_OTHER_CMD = 3'd3,
        EV_SHORT     = 3'd4
    } frame_event_t;

    typedef struct packed {
        logic         store;
        logic [7:0]   value;
        frame_event_t ev;
        logic         dropped;
        logic         fresh;
    } parser_out_t;

    typedef struct packed {
        logic         fresh;
        frame_event_t ev;
        logic         dropped;
    } side_t;

    typedef struct packed {
        logic [7:0] avg;
        side_t      side;
    } out_word_t;

    function automatic int sum_width(input int depth);
        return $clog2(depth * 255 + (depth >> 1) + 1);
    endfunction

endpackage

/* rtl/rfca_parser.sv */
// ----------------------------------------------------------------------------
// rfca_parser
// Frame hunter, checksum check and millisecond age counter.
// ----------------------------------------------------------------------------
module rfca_parser #(
    parameter int FRAME_LIMIT = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 mode,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          timeout_ms,
    input  logic [15:0]          report_command,
    output rfca_pkg::parser_out_t pout
);
    import rfca_pkg::*;

    localparam int BCW = $clog2(FRAME_LIMIT);
    localparam logic [BCW-1:0] LIMIT_LAST = BCW'(FRAME_LIMIT - 1);

    logic [BCW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]     r0_reg, r0_next;
    logic [7:0]     r1_reg, r1_next;
    logic [7:0]     r2_reg, r2_next;
    logic [7:0]     rsum_reg, rsum_next;
    logic [15:0]    cmd_reg, cmd_next;
    logic [15:0]    len_reg, len_next;
    logic [16:0]    elapsed_reg, elapsed_next;
    logic [7:0]     len_div_reg;
    logic [31:0]    len_prod;
    logic [BCW-1:0] pos_inc;
    logic           clear;
    logic           store;
    logic           dropped;
    frame_event_t   ev;

    assign len_prod = {16'h0000, len_reg} * POINT_SIZE_RECIP;
    assign pos_inc  = byte_count_reg + BCW'(1);

    always_comb begin
        byte_count_next = byte_count_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        r2_next         = r2_reg;
        rsum_next       = rsum_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        elapsed_next    = elapsed_reg;
        clear           = 1'b0;
        store           = 1'b0;
        dropped         = 1'b0;
        ev              = EV_NONE;
        if (accept) begin
            if (mode) begin
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 17'd1;
                end
            end else if (byte_count_reg == '0 && data_byte != HEAD0) begin
                clear = 1'b0;
            end else if (byte_count_reg == BCW'(1) && data_byte != HEAD1) begin
                clear = 1'b1;
            end else begin
                rsum_next = rsum_reg + r0_reg;
                r0_next   = r1_reg;
                r1_next   = r2_reg;
                r2_next   = data_byte;
                case (byte_count_reg)
                    BCW'(2): cmd_next = {data_byte, 8'h00};
                    BCW'(3): cmd_next = {cmd_reg[15:8], data_byte};
                    BCW'(4): len_next = {data_byte, 8'h00};
                    BCW'(5): len_next = {len_reg[15:8], data_byte};
                    default: cmd_next = cmd_reg;
                endcase
                byte_count_next = pos_inc;
                if (pos_inc > BCW'(5) && r2_reg == TAIL0 && data_byte == TAIL1) begin
                    if (rsum_next != r1_reg) begin
                        ev = EV_BAD_SUM;
                    end else if (cmd_next != report_command) begin
                        ev = EV_OTHER_CMD;
                    end else if (pos_inc < BCW'(9)) begin
                        ev = EV_SHORT;
                    end else begin
                        ev    = EV_STORED;
                        store = 1'b1;
                    end
                    clear = 1'b1;
                end else if (pos_inc >= LIMIT_LAST) begin
                    clear   = 1'b1;
                    dropped = 1'b1;
                end
            end
        end
        if (clear) begin
            byte_count_next = '0;
            r0_next         = '0;
            r1_next         = '0;
            r2_next         = '0;
            rsum_next       = '0;
            cmd_next        = '0;
            len_next        = '0;
        end
        if (store) begin
            elapsed_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            r0_reg         <= '0;
            r1_reg         <= '0;
            r2_reg         <= '0;
            rsum_reg       <= '0;
            cmd_reg        <= '0;
            len_reg        <= '0;
            elapsed_reg    <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            r0_reg         <= r0_next;
            r1_reg         <= r1_next;
            r2_reg         <= r2_next;
            rsum_reg       <= rsum_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    // points in the report, settles well before the frame can end
    always_ff @(posedge aclk) begin
        len_div_reg <= len_prod[POINT_SIZE_SHIFT +: 8];
    end

    assign pout.store   = store;
    assign pout.value   = len_div_reg;
    assign pout.ev      = ev;
    assign pout.dropped = dropped;
    assign pout.fresh   = !(elapsed_next > {1'b0, timeout_ms});

endmodule

/* rtl/rfca_cell.sv */
// ----------------------------------------------------------------------------
// rfca_cell
// One count of the averaging window, shifts to its neighbor on a store.
// ----------------------------------------------------------------------------
module rfca_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);
    logic [7:0] q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (shift) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

/* rtl/rfca_divider.sv */
// ----------------------------------------------------------------------------
// rfca_divider
// Pipelined divide of the biased window sum by the window depth.
// ----------------------------------------------------------------------------
module rfca_divider #(
    parameter int DIVISOR = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [rfca_pkg::sum_width(DIVISOR)-1:0] in_n,
    input  rfca_pkg::side_t        in_side,
    output logic                   out_valid,
    output rfca_pkg::out_word_t    out_word
);
    import rfca_pkg::*;

    localparam int NW = sum_width(DIVISOR);
    localparam logic [NW-1:0] RECIP = NW'((64'd1 << NW) / DIVISOR);
    localparam logic [NW-1:0] DIV_N = NW'(DIVISOR);

    logic            a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [NW-1:0]   a_n_reg, b_n_reg, c_n_reg;
    side_t           a_side_reg, b_side_reg, c_side_reg;
    logic [2*NW-1:0] b_prod_reg;
    logic [2*NW-1:0] qd_full;
    logic [NW-1:0]   c_q0_reg, c_qd_reg;
    logic [NW-1:0]   rem;
    logic [NW-1:0]   quot;
    out_word_t       d_word_reg;

    assign qd_full = {{NW{1'b0}}, b_prod_reg[2*NW-1:NW]} * {{NW{1'b0}}, DIV_N};
    assign rem     = c_n_reg - c_qd_reg;
    assign quot    = c_q0_reg + NW'(rem >= DIV_N);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_n_reg         <= in_n;
        a_side_reg      <= in_side;
        b_prod_reg      <= {{NW{1'b0}}, a_n_reg} * {{NW{1'b0}}, RECIP};
        b_n_reg         <= a_n_reg;
        b_side_reg      <= a_side_reg;
        c_q0_reg        <= b_prod_reg[2*NW-1:NW];
        c_qd_reg        <= qd_full[NW-1:0];
        c_n_reg         <= b_n_reg;
        c_side_reg      <= b_side_reg;
        d_word_reg.avg  <= quot[7:0];
        d_word_reg.side <= c_side_reg;
    end

    assign out_valid = d_valid_reg;
    assign out_word  = d_word_reg;

endmodule

/* rtl/rfca_fifo.sv */
// ----------------------------------------------------------------------------
// rfca_fifo
// Small show-ahead result buffer between the pipeline and the result port.
// ----------------------------------------------------------------------------
module rfca_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  rfca_pkg::out_word_t wr_data,
    input  logic                rd_en,
    output rfca_pkg::out_word_t rd_data,
    output logic                not_empty
);
    import rfca_pkg::*;

    out_word_t         mem [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_AW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_AW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_AW'(1);
            end
            count_reg <= count_reg + (OUT_AW + 1)'(wr_en) - (OUT_AW + 1)'(rd_en);
        end
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

/* rtl/radar_frame_count_averager.sv */
// ----------------------------------------------------------------------------
// radar_frame_count_averager
// Radar frame parser with a moving average of reported target counts.
//
// s_ carries one word per serial byte (s_mode 0) or per millisecond tick
// (s_mode 1). Every accepted word gives exactly one m_ word holding the
// rounded average of the last AVERAGE_DEPTH stored counts, a freshness flag,
// the frame event and the overflow flag.
// Accepted words reach m_valid through the divider and the result buffer. One
// word per cycle is taken while s_ready is high; the parser and the count
// window update in the acceptance cycle and the division by the window depth
// runs in a four-stage multiply pipeline. Results wait in an 8-word buffer;
// s_ready drops only while 8 words are accepted and not yet taken, so a stalled
// receiver holds off new input after that and nothing is lost.
// The count window is a row of AVERAGE_DEPTH cells that reset clears at once,
// so the block accepts input in the first cycle after reset.
// cfg_ writes are always taken: index 0 timeout_ms, index 1 report_command,
// other indexes are ignored. Write them while the block is idle.
// ----------------------------------------------------------------------------
module radar_frame_count_averager #(
    parameter int FRAME_LIMIT   = 256,
    parameter int AVERAGE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_average_count,
    output logic        m_count_valid,
    output logic [2:0]  m_frame_event,
    output logic        m_frame_dropped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rfca_pkg::*;

    localparam int SW = sum_width(AVERAGE_DEPTH);
    localparam logic [OUT_AW:0] OCC_MAX = (OUT_AW + 1)'(OUT_DEPTH);

    logic [15:0]     timeout_reg;
    logic [15:0]     report_reg;
    logic            s_accept;
    logic            m_accept;
    parser_out_t     pout;
    logic [7:0]      tap [0:AVERAGE_DEPTH];
    logic [SW-1:0]   sum_reg, sum_next;
    side_t           side;
    logic            div_valid;
    out_word_t       div_word;
    out_word_t       rd_word;
    logic [OUT_AW:0] occ_reg;

    assign s_accept  = s_valid && s_ready;
    assign m_accept  = m_valid && m_ready;
    assign s_ready   = (occ_reg < OCC_MAX);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            report_reg  <= REPORT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT_MS:     timeout_reg <= cfg_data;
                CFG_REPORT_COMMAND: report_reg  <= cfg_data;
                default:            timeout_reg <= timeout_reg;
            endcase
        end
    end

    rfca_parser #(
        .FRAME_LIMIT(FRAME_LIMIT)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .mode          (s_mode),
        .data_byte     (s_data_byte),
        .timeout_ms    (timeout_reg),
        .report_command(report_reg),
        .pout          (pout)
    );

    assign tap[0] = pout.value;

    for (genvar i = 0; i < AVERAGE_DEPTH; i++) begin : g_cell
        rfca_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .shift  (pout.store),
            .d      (tap[i]),
            .q      (tap[i+1])
        );
    end

    // window sum carries the rounding half
    assign sum_next = pout.store
                    ? sum_reg - SW'(tap[AVERAGE_DEPTH]) + SW'(pout.value)
                    : sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= SW'(AVERAGE_DEPTH / 2);
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign side.fresh   = pout.fresh;
    assign side.ev      = pout.ev;
    assign side.dropped = pout.dropped;

    rfca_divider #(
        .DIVISOR(AVERAGE_DEPTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_accept),
        .in_n     (sum_next),
        .in_side  (side),
        .out_valid(div_valid),
        .out_word (div_word)
    );

    rfca_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (div_valid),
        .wr_data  (div_word),
        .rd_en    (m_accept),
        .rd_data  (rd_word),
        .not_empty(m_valid)
    );

    // words accepted and not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_reg + (OUT_AW + 1)'(s_accept) - (OUT_AW + 1)'(m_accept);
        end
    end

    assign m_average_count = rd_word.avg;
    assign m_count_valid   = rd_word.side.fresh;
    assign m_frame_event   = rd_word.side.ev;
    assign m_frame_dropped = rd_word.side.dropped;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_MAX)
        else $error("outstanding words exceed result buffer");

    a_valid_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (occ_reg != '0))
        else $error("result word without an accepted input");

    a_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_mode) |-> (pout.ev == EV_NONE && !pout.dropped && !pout.store))
        else $error("tick changed frame state");

    a_store_event: assert property (@(posedge aclk) disable iff (!aresetn)
        pout.store |-> (s_accept && pout.ev == EV_STORED))
        else $error("count stored without a stored event");

endmodule
